[design/can_bts_pkg.sv]
// Package: widths, register indexes and solver state codes for the CAN bit timing solver.
package can_bts_pkg;

    localparam int CLK_W      = 32;
    localparam int RATE_W     = 27;
    localparam int PSC_W      = 11;
    localparam int SJW_W      = 8;
    localparam int QPB_W      = 5;
    localparam int SEG1_W     = 5;
    localparam int SEG2_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int STEP_W     = 5;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CLK_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SJW_LIMIT     = 2'd2;

    localparam logic [PSC_W-1:0] PSC_MIN_RESET = 11'd1;
    localparam logic [PSC_W-1:0] PSC_MAX_RESET = 11'd1024;
    localparam logic [SJW_W-1:0] SJW_RESET     = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } solver_state_t;

endpackage

[design/can_bit_timing_solver_top.sv]
// Top level: CAN bit timing solver with a bit-serial restoring divider.
//
//  channel | signals                                        | transfer
//  --------+------------------------------------------------+-----------------------------
//  in      | in_valid, in_ready, clk_freq, bit_rate         | valid & ready at clk edge
//  out     | out_valid, out_ready, status, prescaler,       | valid & ready at clk edge
//          | quanta_per_bit, phase_seg1, phase_seg2, sync_jump |
//  cfg     | cfg_wr_en, cfg_index, cfg_data                 | write when cfg_wr_en high
//
// Each quanta count tried takes a step to form bitrate * q, 32 divider steps
// (one quotient bit per cycle), and a step to check remainder and prescaler limits.
// Counts are tried from QUANTA_MAX down to QUANTA_MIN until one fits;
// a zero clock or bit rate skips the search. One item is solved at a time.
// The output register holds a result while out_ready is low; the next transaction
// is accepted meanwhile. Reset clears the control state and loads the config registers with their defaults.
module can_bit_timing_solver_top
    import can_bts_pkg::*;
#(
    parameter int QUANTA_MAX = 25,
    parameter int QUANTA_MIN = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CLK_W-1:0]      clk_freq,
    input  logic [RATE_W-1:0]     bit_rate,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  status,
    output logic [PSC_W-1:0]      prescaler,
    output logic [QPB_W-1:0]      quanta_per_bit,
    output logic [SEG1_W-1:0]     phase_seg1,
    output logic [SEG2_W-1:0]     phase_seg2,
    output logic [SEG2_W-1:0]     sync_jump,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QW = $clog2(QUANTA_MAX + 1);
    localparam int DW = RATE_W + QW;
    localparam int SW = (QW + 2 > SJW_W) ? QW + 2 : SJW_W;
    localparam logic NO_RANGE = (QUANTA_MAX < QUANTA_MIN);
    localparam logic [QW-1:0] Q_FIRST = QW'(QUANTA_MAX);
    localparam logic [QW-1:0] Q_LAST  = QW'(QUANTA_MIN);

    solver_state_t state_reg, state_next;

    logic [PSC_W-1:0]  psc_min_reg, psc_max_reg;
    logic [SJW_W-1:0]  sjw_lim_reg;

    logic [CLK_W-1:0]  clk_hold_reg, clk_hold_next;
    logic [CLK_W-1:0]  clk_sh_reg, clk_sh_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [DW-1:0]     denom_reg, denom_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              found_reg, found_next;

    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic [PSC_W-1:0]  psc_reg, psc_next;
    logic [QPB_W-1:0]  qpb_reg, qpb_next;
    logic [SEG1_W-1:0] seg1_reg, seg1_next;
    logic [SEG2_W-1:0] seg2_reg, seg2_next;
    logic [SEG2_W-1:0] sjw_reg, sjw_next;

    logic [DW:0]       trial;
    logic              trial_ge;
    logic [SW-1:0]     qm1, seg1_w, seg2_w, lim_w, sjw_w;
    logic              fits;

    // Divider step: bring down the next dividend bit and try a subtract
    assign trial    = {rem_reg, clk_sh_reg[CLK_W-1]};
    assign trial_ge = (trial >= {1'b0, denom_reg});

    assign fits = (rem_reg == '0)
               && (quo_reg >= CLK_W'(psc_min_reg))
               && (quo_reg <= CLK_W'(psc_max_reg));

    // Segment split for a 75 percent sample point
    assign qm1    = SW'(q_reg) - SW'(1);
    assign seg1_w = (qm1 * SW'(3)) >> 2;
    assign seg2_w = qm1 - seg1_w;
    assign lim_w  = SW'(sjw_lim_reg);
    assign sjw_w  = (seg2_w < lim_w) ? seg2_w : lim_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psc_min_reg <= PSC_MIN_RESET;
            psc_max_reg <= PSC_MAX_RESET;
            sjw_lim_reg <= SJW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PRESCALER_MIN: psc_min_reg <= cfg_data;
                REG_PRESCALER_MAX: psc_max_reg <= cfg_data;
                REG_SJW_LIMIT:     sjw_lim_reg <= cfg_data[SJW_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clk_hold_reg <= clk_hold_next;
        clk_sh_reg   <= clk_sh_next;
        rate_reg     <= rate_next;
        q_reg        <= q_next;
        denom_reg    <= denom_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        status_reg   <= status_next;
        psc_reg      <= psc_next;
        qpb_reg      <= qpb_next;
        seg1_reg     <= seg1_next;
        seg2_reg     <= seg2_next;
        sjw_reg      <= sjw_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clk_hold_next  = clk_hold_reg;
        clk_sh_next    = clk_sh_reg;
        rate_next      = rate_reg;
        q_next         = q_reg;
        denom_next     = denom_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        psc_next       = psc_reg;
        qpb_next       = qpb_reg;
        seg1_next      = seg1_reg;
        seg2_next      = seg2_reg;
        sjw_next       = sjw_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    clk_hold_next = clk_freq;
                    rate_next     = bit_rate;
                    q_next        = Q_FIRST;
                    found_next    = 1'b0;
                    if (clk_freq == '0 || bit_rate == '0 || NO_RANGE)
                        state_next = ST_DONE;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                denom_next  = DW'(rate_reg) * DW'(q_reg);
                clk_sh_next = clk_hold_reg;
                rem_next    = '0;
                quo_next    = '0;
                step_next   = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                clk_sh_next = clk_sh_reg << 1;
                quo_next    = {quo_reg[CLK_W-2:0], trial_ge};
                rem_next    = trial_ge ? DW'(trial - {1'b0, denom_reg}) : DW'(trial);
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (fits)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (q_reg == Q_LAST)
                    state_next = ST_DONE;
                else
                begin
                    q_next     = q_reg - QW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = !found_reg;
                    if (found_reg)
                    begin
                        psc_next  = quo_reg[PSC_W-1:0];
                        qpb_next  = QPB_W'(q_reg);
                        seg1_next = seg1_w[SEG1_W-1:0];
                        seg2_next = seg2_w[SEG2_W-1:0];
                        sjw_next  = sjw_w[SEG2_W-1:0];
                    end
                    else
                    begin
                        psc_next  = '0;
                        qpb_next  = '0;
                        seg1_next = '0;
                        seg2_next = '0;
                        sjw_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign prescaler      = psc_reg;
    assign quanta_per_bit = qpb_reg;
    assign phase_seg1     = seg1_reg;
    assign phase_seg2     = seg2_reg;
    assign sync_jump      = sjw_reg;

endmodule

[design/can_bts_checker.sv]
// Checker: port-level assertions for the CAN bit timing solver, bound to the top level.
module can_bts_checker
    import can_bts_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              status,
    input logic [PSC_W-1:0]  prescaler,
    input logic [QPB_W-1:0]  quanta_per_bit,
    input logic [SEG1_W-1:0] phase_seg1,
    input logic [SEG2_W-1:0] phase_seg2,
    input logic [SEG2_W-1:0] sync_jump
);

    // Stalled result keeps its status, prescaler, quanta count and sync jump
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(prescaler)
            && $stable(quanta_per_bit) && $stable(sync_jump))
        else $error("result changed while stalled");

    // One solve at a time: busy right after a transaction is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while solving");

    // Failure zeroes every field
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> prescaler == '0 && quanta_per_bit == '0
            && phase_seg1 == '0 && phase_seg2 == '0 && sync_jump == '0)
        else $error("failure result with nonzero fields");

    // An exact division of a nonzero clock never yields a zero prescaler
    a_psc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> prescaler != '0)
        else $error("solved result with zero prescaler");

endmodule

bind can_bit_timing_solver_top can_bts_checker u_can_bts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .prescaler      (prescaler),
    .quanta_per_bit (quanta_per_bit),
    .phase_seg1     (phase_seg1),
    .phase_seg2     (phase_seg2),
    .sync_jump      (sync_jump)
);

[tb/can_bit_timing_solver_top_tb.sv]
// Testbench for the CAN bit timing solver: directed and random requests checked against a predictor.
module can_bit_timing_solver_top_tb
    import can_bts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUANTA_MAX = 25;
    localparam int QUANTA_MIN = 8;
    localparam int unsigned RATE_TOP = (1 << RATE_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              status;
        logic [PSC_W-1:0]  prescaler;
        logic [QPB_W-1:0]  quanta;
        logic [SEG1_W-1:0] seg1;
        logic [SEG2_W-1:0] seg2;
        logic [SEG2_W-1:0] sjw;
    } bit_timing_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CLK_W-1:0]      clk_freq;
    logic [RATE_W-1:0]     bit_rate;
    logic                  out_valid;
    logic                  out_ready;
    logic                  status;
    logic [PSC_W-1:0]      prescaler;
    logic [QPB_W-1:0]      quanta_per_bit;
    logic [SEG1_W-1:0]     phase_seg1;
    logic [SEG2_W-1:0]     phase_seg2;
    logic [SEG2_W-1:0]     sync_jump;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register copies used by the predictor
    logic [PSC_W-1:0] psc_lo;
    logic [PSC_W-1:0] psc_hi;
    logic [SJW_W-1:0] sjw_cap;

    bit_timing_t expected_timings[$];
    int          mismatch_count = 0;
    bit          gapless = 1'b0;
    int unsigned hold_request = 0;
    int unsigned stall_left = 0;

    can_bit_timing_solver_top #(
        .QUANTA_MAX(QUANTA_MAX),
        .QUANTA_MIN(QUANTA_MIN)
    ) dut (.*);

    always #5 clk = ~clk;

    function automatic bit_timing_t solve_bit_timing(input logic [CLK_W-1:0] c,
                                                     input logic [RATE_W-1:0] r);
        bit_timing_t     t;
        longint unsigned denom;
        longint unsigned psc;
        int              s1;
        int              s2;
        bit              found;
        t = '0;
        t.status = 1'b1;
        found = 1'b0;
        if (c != 0 && r != 0)
        begin
            // largest quanta count that fits wins
            for (int q = QUANTA_MAX; q >= QUANTA_MIN; q--)
            begin
                denom = longint'(r) * longint'(q);
                if (!found && q > 0 && denom <= c && (c % denom) == 0)
                begin
                    psc = c / denom;
                    if (psc >= psc_lo && psc <= psc_hi)
                    begin
                        found = 1'b1;
                        s1 = ((q - 1) * 3) / 4;
                        s2 = (q - 1) - s1;
                        t.status = 1'b0;
                        t.prescaler = psc[PSC_W-1:0];
                        t.quanta = q[QPB_W-1:0];
                        t.seg1 = s1[SEG1_W-1:0];
                        t.seg2 = s2[SEG2_W-1:0];
                        t.sjw = (s2 < sjw_cap) ? s2[SEG2_W-1:0] : sjw_cap[SEG2_W-1:0];
                    end
                end
            end
        end
        return t;
    endfunction

    // Result checker
    always @(posedge clk)
    begin : result_monitor
        bit_timing_t seen;
        bit_timing_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {status, prescaler, quanta_per_bit, phase_seg1, phase_seg2, sync_jump};
                if (expected_timings.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result st=%0d psc=%0d q=%0d", $realtime,
                                 seen.status, seen.prescaler, seen.quanta);
                end
                else
                begin
                    want = expected_timings.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: timing mismatch exp st=%0d psc=%0d q=%0d s1=%0d ",
                                      "s2=%0d sjw=%0d got st=%0d psc=%0d q=%0d s1=%0d s2=%0d ",
                                      "sjw=%0d"}, $realtime,
                                     want.status, want.prescaler, want.quanta, want.seg1,
                                     want.seg2, want.sjw, seen.status, seen.prescaler,
                                     seen.quanta, seen.seg1, seen.seg2, seen.sjw);
                    end
                end
            end
        end
    end

    // Receiver back-pressure: random gaps plus a long hold-off on request
    always @(posedge clk)
    begin : sink_ready
        if (rst_n)
        begin
            if (hold_request != 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= gapless || ($urandom_range(0, 99) >= 16);
        end
    end

    // Offer one request and hold it until the transaction completes
    task automatic send_request(input logic [CLK_W-1:0] c, input logic [RATE_W-1:0] r);
        while (!gapless && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        clk_freq <= c;
        bit_rate <= r;
        do
            @(posedge clk);
        while (!in_ready);
        expected_timings.push_back(solve_bit_timing(c, r));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_timings.size() != 0)
            @(posedge clk);
    endtask

    // Write all registers back to back; the block must be idle
    task automatic set_limits(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [CFG_DATA_W-1:0] sjw_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PRESCALER_MIN;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_PRESCALER_MAX;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= REG_SJW_LIMIT;
        cfg_data <= sjw_word;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        psc_lo = lo[PSC_W-1:0];
        psc_hi = hi[PSC_W-1:0];
        sjw_cap = sjw_word[SJW_W-1:0];
    endtask

    // Mostly requests built to divide evenly, plus near misses and noise
    task automatic pick_request(output logic [CLK_W-1:0] c, output logic [RATE_W-1:0] r);
        int unsigned     kind;
        int unsigned     q;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     psc;
        longint unsigned span;
        longint unsigned rmax;
        longint unsigned prod;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            q = $urandom_range(QUANTA_MIN, QUANTA_MAX);
            lo = (psc_lo == 0) ? 1 : psc_lo;
            hi = psc_hi;
            if (lo <= hi)
            begin
                if ($urandom_range(0, 1) && hi > lo + 15)
                    hi = lo + 15;
                psc = $urandom_range(lo, hi);
            end
            else
                psc = $urandom_range(1, 2047);
            span = longint'(q) * longint'(psc);
            rmax = 64'hFFFF_FFFF / span;
            if (rmax > RATE_TOP)
                rmax = RATE_TOP;
            if ($urandom_range(0, 1) && rmax > 1000000)
                rmax = 1000000;
            r = RATE_W'($urandom_range(1, int'(rmax)));
            prod = longint'(r) * span;
            // near miss: shift the clock off the exact multiple
            if (kind >= 58)
                prod = (prod == 64'hFFFF_FFFF) ? prod - 1 : prod + 1;
            c = prod[CLK_W-1:0];
        end
        else if (kind < 85)
        begin
            c = $urandom;
            r = RATE_W'($urandom_range(0, RATE_TOP));
        end
        else if (kind < 92)
        begin
            c = $urandom;
            r = RATE_W'($urandom_range(1, 1000));
        end
        else if (kind < 96)
        begin
            // rate times smallest quanta count already above the clock
            r = RATE_W'($urandom_range(1000, RATE_TOP));
            c = $urandom_range(1, r * 8 - 1);
        end
        else
        begin
            c = $urandom_range(0, 1) ? 0 : $urandom;
            r = (c == 0 && $urandom_range(0, 1)) ? RATE_W'($urandom_range(0, RATE_TOP))
                                                 : RATE_W'(0);
        end
    endtask

    task automatic send_random(input int count);
        logic [CLK_W-1:0]  c;
        logic [RATE_W-1:0] r;
        repeat (count)
        begin
            pick_request(c, r);
            send_request(c, r);
        end
    endtask

    task automatic test_reset_defaults;
        send_request(32'd0, 27'd500000);
        send_request(32'd80000000, 27'd0);
        send_request(32'd0, 27'd0);
        send_request(32'd80000000, 27'd500000);
        send_request(32'd80000000, 27'd1000000);
        send_request(32'd8000000, 27'd1000000);
        send_request(32'd24000000, 27'd1000000);
        send_request(32'd40000000, 27'd125000);
        send_request(32'hFFFF_FFFF, 27'd1);
        send_request(32'hFFFF_FFFF, 27'(RATE_TOP));
        send_request(32'd100000000, 27'd4000000);
        send_request(32'd100, 27'd1000);
        send_request(32'd8192000, 27'd1000);
        send_request(32'd24600000, 27'd3000);
        send_request(32'd8, 27'd1);
        send_request(32'd3276800, 27'd400);
        drain();
    endtask

    task automatic test_register_extremes;
        set_limits(11'd0, 11'h7FF, 11'h7FF);
        send_random(15);
        drain();
        // crossed limits: nothing can fit
        set_limits(11'd1024, 11'd1, 11'd0);
        send_request(32'd80000000, 27'd500000);
        send_random(14);
        drain();
        // sjw register keeps only its low byte, so this clears it
        set_limits(11'h7FF, 11'h7FF, 11'h300);
        send_random(15);
        drain();
        set_limits(11'd1, 11'd1, 11'd128);
        send_request(32'd25000000, 27'd1000000);
        send_random(14);
        drain();
        set_limits(11'd1024, 11'd1024, 11'd1);
        send_random(15);
        drain();
    endtask

    task automatic test_steady_stream;
        set_limits(11'd1, 11'd1024, 11'd4);
        gapless = 1'b1;
        send_random(150);
        drain();
        gapless = 1'b0;
    endtask

    task automatic test_backpressure;
        hold_request = 2000;
        // fast failures fill the solver and the output register first
        send_request(32'd0, 27'd1);
        send_request(32'd1, 27'd0);
        send_request(32'd0, 27'd0);
        send_request(32'd0, 27'd7);
        send_random(12);
        drain();
    endtask

    task automatic test_random_sweep;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_limits(11'd1, 11'd1024, 11'd4);
            else
            begin
                lo = CFG_DATA_W'($urandom_range(0, 40));
                hi = $urandom_range(0, 3) == 0 ? 11'h7FF
                                               : CFG_DATA_W'($urandom_range(lo, 1024));
                set_limits(lo, hi, CFG_DATA_W'($urandom_range(0, 11'h7FF)));
            end
            send_random(130);
            drain();
        end
    endtask

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        clk_freq = '0;
        bit_rate = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_PRESCALER_MIN;
        cfg_data = '0;
        psc_lo = PSC_MIN_RESET;
        psc_hi = PSC_MAX_RESET;
        sjw_cap = SJW_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_steady_stream();
        test_backpressure();
        test_random_sweep();

        // catch stray results after the last one
        repeat (700) @(posedge clk);
        if (mismatch_count == 0 && expected_timings.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
